>>> hw/rtl/tfcs_pkg.sv
package tfcs_pkg;

    localparam int DEFAULT_LINE_LIMIT = 512;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_MODE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_DELIMITER = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH      = 4'd3;

    localparam logic [7:0]  NEWLINE         = 8'd10;
    localparam logic [7:0]  RESET_DELIMITER = 8'd9;
    localparam logic [15:0] RESET_RANGE     = 16'd1;
    localparam logic [15:0] FIELD_FIRST     = 16'd1;
    localparam logic [15:0] FIELD_MAX       = 16'hFFFF;

    typedef struct packed {
        logic        column_mode;
        logic [7:0]  field_delimiter;
        logic [15:0] range_low;
        logic [15:0] range_high;
    } cfg_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] value;
    } sel_t;

    // Range test on a 17-bit number so a column count never wraps.
    function automatic logic in_range(input logic [16:0] n, input logic [15:0] low,
                                      input logic [15:0] high);
        in_range = (n >= {1'b0, low}) && (n <= {1'b0, high});
    endfunction

endpackage

>>> hw/rtl/tfcs_cfg.sv
module tfcs_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [tfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfcs_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            cfg_ready,
    output tfcs_pkg::cfg_t                  cfg
);

    tfcs_pkg::cfg_t cfg_reg;
    tfcs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                tfcs_pkg::CFG_COLUMN_MODE:     cfg_next.column_mode     = cfg_data[0];
                tfcs_pkg::CFG_FIELD_DELIMITER: cfg_next.field_delimiter = cfg_data[7:0];
                tfcs_pkg::CFG_RANGE_LOW:       cfg_next.range_low       = cfg_data;
                tfcs_pkg::CFG_RANGE_HIGH:      cfg_next.range_high      = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.column_mode     <= 1'b0;
            cfg_reg.field_delimiter <= tfcs_pkg::RESET_DELIMITER;
            cfg_reg.range_low       <= tfcs_pkg::RESET_RANGE;
            cfg_reg.range_high      <= tfcs_pkg::RESET_RANGE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/tfcs_select.sv
module tfcs_select #(
    parameter int LINE_LIMIT = tfcs_pkg::DEFAULT_LINE_LIMIT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     in_byte,
    input  tfcs_pkg::cfg_t cfg,
    output tfcs_pkg::sel_t sel
);

    localparam int POS_W = (LINE_LIMIT > 2) ? $clog2(LINE_LIMIT) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_LIMIT - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      field_reg, field_next;
    logic             seen_reg, seen_next;

    logic [16:0] column;
    logic [15:0] field_inc;
    logic        emit;
    logic [7:0]  value;

    assign column    = 17'(pos_reg) + 17'd1;
    assign field_inc = (field_reg == tfcs_pkg::FIELD_MAX) ? tfcs_pkg::FIELD_MAX
                                                          : field_reg + 16'd1;

    always_comb
    begin
        pos_next   = pos_reg;
        field_next = field_reg;
        seen_next  = seen_reg;
        emit       = 1'b0;
        value      = in_byte;
        if (accept)
        begin
            if (in_byte == tfcs_pkg::NEWLINE)
            begin
                pos_next   = '0;
                field_next = tfcs_pkg::FIELD_FIRST;
                seen_next  = 1'b0;
                emit       = 1'b1;
            end
            else if (pos_reg != POS_LAST)
            begin
                // Bytes past the line limit leave all state untouched.
                pos_next = pos_reg + POS_W'(1);
                if (cfg.column_mode)
                begin
                    emit = tfcs_pkg::in_range(column, cfg.range_low, cfg.range_high);
                end
                else if (in_byte == cfg.field_delimiter)
                begin
                    seen_next  = seen_reg | tfcs_pkg::in_range({1'b0, field_reg},
                                                               cfg.range_low, cfg.range_high);
                    emit       = seen_next && tfcs_pkg::in_range({1'b0, field_inc},
                                                                 cfg.range_low, cfg.range_high);
                    field_next = field_inc;
                end
                else
                begin
                    emit = tfcs_pkg::in_range({1'b0, field_reg}, cfg.range_low, cfg.range_high);
                end
            end
        end
        sel.emit  = emit && (cfg.range_low != 16'd0);
        sel.value = value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            field_reg <= tfcs_pkg::FIELD_FIRST;
            seen_reg  <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            field_reg <= field_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

>>> hw/rtl/tfcs_out.sv
module tfcs_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  tfcs_pkg::sel_t sel,
    input  logic           out_stall,
    output logic           out_valid,
    output logic [7:0]     out_byte,
    output logic           busy
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;

    // A new beat may enter whenever the held one leaves in this cycle.
    assign busy      = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (accept)
        begin
            valid_next = sel.emit;
            byte_next  = sel.value;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

>>> hw/rtl/text_field_column_selector_core.sv
// Cut-style field and column selector: one text byte per cycle in, at most one byte per cycle
// out, through a single output register loaded on accept. Each accepted byte updates
// the line position, field number and selected-field flag in the same cycle, so a new byte
// is taken every cycle unless the output register holds a stalled beat. Newline always
// passes (when range_low is nonzero) and restarts the line; lines keep only their first
// LINE_LIMIT-1 bytes. Configuration writes are taken at any time with ready tied high but
// should only be made while the stream is idle.
module text_field_column_selector_core #(
    parameter int LINE_LIMIT = tfcs_pkg::DEFAULT_LINE_LIMIT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      in_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_byte,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfcs_pkg::CFG_DATA_W-1:0] cfg_data
);

    tfcs_pkg::cfg_t cfg;
    tfcs_pkg::sel_t sel;
    logic           accept;
    logic           busy;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    tfcs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    tfcs_select #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .cfg     (cfg),
        .sel     (sel)
    );

    tfcs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sel       (sel),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .busy      (busy)
    );

endmodule

>>> hw/rtl/tfcs_checker.sv
module tfcs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte
);

    // A stalled output beat stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte))
        else $error("stalled output beat changed");

    // The input side only stalls behind a held output beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output beat");

    // A fresh output beat must come from an input beat taken in the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !(out_valid && out_stall) && !(in_valid && !in_stall)
        |=> !out_valid)
        else $error("output beat appeared without an input beat");

    // Once the output drains with no input, nothing is left behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(in_valid && !in_stall) |=> !out_valid)
        else $error("output beat invented while idle");

endmodule

bind text_field_column_selector_core tfcs_checker u_tfcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte)
);
